// ===== sv/lru_block_cache_directory_defines.svh =====
// ----------------------------------------------------------------------------
// LRU block cache directory assertion macros
// Concurrent assertion helpers used by the file that checks the directory.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH

`ifndef SYNTHESIS
// Condition in the same cycle.
`define LBCD_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lbcd assertion failed");
// Condition in the next cycle.
`define LBCD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lbcd assertion failed");
`else
`define LBCD_ASSERT_SAME(name, clk, rst, pre, post)
`define LBCD_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// ===== sv/lbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory package
// Field widths, default sizes, command and status codes, shared types.
// ----------------------------------------------------------------------------
package lbcd_pkg;

   // Default directory geometry.
   localparam int DEFAULT_ENTRIES    = 16;
   localparam int DEFAULT_BLOCK_BITS = 32;

   // Fixed widths of the channel fields.
   localparam int CMD_W          = 1;
   localparam int BLOCK_NUMBER_W = 32;
   localparam int STATUS_W       = 3;
   localparam int SLOT_W         = 4;
   localparam int VICTIM_W       = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACCESS  = 1'b0,
      CMD_RECLAIM = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT       = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_RECLAIMED = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Operation control handed to the directory store.
   typedef struct packed {
      logic    fire;
      cmd_type cmd;
   } op_type;

endpackage

// ===== sv/lbcd_req_if.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface lbcd_req_if import lbcd_pkg::*; ();

   logic                      valid;
   logic                      ready;
   cmd_type                   command;
   logic [BLOCK_NUMBER_W-1:0] block_number;

   modport source (output valid, output command, output block_number, input ready);
   modport sink   (input valid, input command, input block_number, output ready);

endinterface

// ===== sv/lbcd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface lbcd_rsp_if import lbcd_pkg::*; ();

   logic                valid;
   logic                ready;
   status_type          status;
   logic [SLOT_W-1:0]   slot;
   logic [VICTIM_W-1:0] victim_block;

   modport source (output valid, output status, output slot, output victim_block,
                   input ready);
   modport sink   (input valid, input status, input slot, input victim_block,
                   output ready);

endinterface

// ===== sv/lbcd_dir.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory store
// Tag, valid and recency rank per slot, with a parallel lookup and a
// registered update of every slot when an operation fires.
// ----------------------------------------------------------------------------
module lbcd_dir import lbcd_pkg::*; #(
   parameter int  ENTRIES    = DEFAULT_ENTRIES,
   parameter int  BLOCK_BITS = DEFAULT_BLOCK_BITS,
   localparam int IDX_W      = $clog2(ENTRIES),
   localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  op_type                op,
   input  logic [BLOCK_BITS-1:0] block,
   output status_type            status,
   output logic [IDX_W-1:0]      index,
   output logic [BLOCK_BITS-1:0] victim,
   output logic [CNT_W-1:0]      count
);

   logic [BLOCK_BITS-1:0] tag_ff   [ENTRIES];
   logic [IDX_W-1:0]      rank_ff  [ENTRIES];
   logic [IDX_W-1:0]      rank_in  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    valid_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    oldest;
   logic                  hit_found;
   logic                  free_found;
   logic                  lru_found;
   logic [IDX_W-1:0]      hit_idx;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      lru_idx;
   logic [IDX_W-1:0]      hit_rank;
   logic [IDX_W-1:0]      top_rank;
   logic                  tag_write;

   // Per-slot tag compare and least recent flag.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (tag_ff[i] == block);
         oldest[i] = valid_ff[i] && (rank_ff[i] == '0);
      end
   end

   // Lowest-index priority pick for hit, free slot and least recent slot.
   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      lru_found  = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      lru_idx    = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_found = 1'b1;
            hit_idx   = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
         if (oldest[i]) begin
            lru_found = 1'b1;
            lru_idx   = IDX_W'(i);
         end
      end
   end

   assign hit_rank = rank_ff[hit_idx];
   // Most recent rank among the current entries.
   assign top_rank = IDX_W'(count_ff - 1'b1);

   // Outcome of the operation.
   always_comb begin
      status = ST_FULL;
      index  = '0;
      victim = '0;
      case (op.cmd)
         CMD_ACCESS: begin
            if (hit_found) begin
               status = ST_HIT;
               index  = hit_idx;
            end else if (free_found) begin
               status = ST_INSERTED;
               index  = free_idx;
            end else begin
               status = ST_FULL;
            end
         end
         CMD_RECLAIM: begin
            if (lru_found) begin
               status = ST_RECLAIMED;
               index  = lru_idx;
               victim = tag_ff[lru_idx];
            end else begin
               status = ST_EMPTY;
            end
         end
         default: begin
            status = ST_FULL;
         end
      endcase
   end

   // Next state of every slot; ranks above the removed or promoted one shift down.
   always_comb begin
      valid_in  = valid_ff;
      count_in  = count_ff;
      tag_write = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (op.fire) begin
         case (status)
            ST_HIT: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_idx == IDX_W'(i)) begin
                     rank_in[i] = top_rank;
                  end else if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
                     rank_in[i] = rank_ff[i] - 1'b1;
                  end
               end
            end
            ST_INSERTED: begin
               tag_write          = 1'b1;
               valid_in[free_idx] = 1'b1;
               rank_in[free_idx]  = IDX_W'(count_ff);
               count_in           = count_ff + 1'b1;
            end
            ST_RECLAIMED: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (lru_idx == IDX_W'(i)) begin
                     rank_in[i]  = '0;
                     valid_in[i] = 1'b0;
                  end else if (valid_ff[i] && (rank_ff[i] != '0)) begin
                     rank_in[i] = rank_ff[i] - 1'b1;
                  end
               end
               count_in = count_ff - 1'b1;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Tag store is written on insert only.
   always_ff @(posedge clock) begin
      if (tag_write) begin
         tag_ff[free_idx] <= block;
      end
   end

   assign count = count_ff;

endmodule

// ===== sv/lru_block_cache_directory.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory
// Fully associative directory of block numbers in least to most recent order.
// ----------------------------------------------------------------------------
// The directory takes one word per clock while the consumer is ready and
// returns exactly one result word for each. A word is registered on
// acceptance. Once the result register is free or being emptied, it is
// looked up against all ENTRIES slots by a parallel tag compare and rank
// update, and its result is loaded into the output register. With the
// consumer ready, a new word can follow every cycle. While a result waits
// for the consumer, the input register holds one more word and then the
// request side stalls until the result is taken. An access that hits makes
// the slot most recent; a miss fills the lowest free slot as most recent or
// reports full. A reclaim frees the least recent slot and returns its block
// number, or reports empty. Block numbers are held in BLOCK_BITS bits.
`include "lru_block_cache_directory_defines.svh"

module lru_block_cache_directory import lbcd_pkg::*; #(
   parameter int ENTRIES    = DEFAULT_ENTRIES,
   parameter int BLOCK_BITS = DEFAULT_BLOCK_BITS
) (
   input logic      clock,
   input logic      reset,
   lbcd_req_if.sink   req_chan,
   lbcd_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   cmd_type               in_cmd_ff;
   logic [BLOCK_BITS-1:0] in_block_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [VICTIM_W-1:0]   rsp_victim_ff;

   logic                  advance;
   logic                  req_take;
   op_type                dir_op;
   status_type            lk_status;
   logic [IDX_W-1:0]      lk_index;
   logic [BLOCK_BITS-1:0] lk_victim;
   logic [CNT_W-1:0]      dir_count;

   logic                  do_ins;
   logic                  do_rcl;
   logic                  do_emp;
   logic                  do_full;

   // Handshake: the held word moves on when the result register is free.
   assign advance          = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign in_valid_in      = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in     = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_chan.command;
         in_block_ff <= BLOCK_BITS'(req_chan.block_number);
      end
   end

   // Directory lookup and update.
   assign dir_op.fire = advance;
   assign dir_op.cmd  = in_cmd_ff;

   lbcd_dir #(
      .ENTRIES    (ENTRIES),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_dir (
      .clock  (clock),
      .reset  (reset),
      .op     (dir_op),
      .block  (in_block_ff),
      .status (lk_status),
      .index  (lk_index),
      .victim (lk_victim),
      .count  (dir_count)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= lk_status;
         rsp_slot_ff   <= SLOT_W'(lk_index);
         rsp_victim_ff <= VICTIM_W'(lk_victim);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot         = rsp_slot_ff;
   assign rsp_chan.victim_block = rsp_victim_ff;

   // Outcomes of the word that is being processed.
   assign do_ins  = advance && (lk_status == ST_INSERTED);
   assign do_rcl  = advance && (lk_status == ST_RECLAIMED);
   assign do_emp  = advance && (lk_status == ST_EMPTY);
   assign do_full = advance && (lk_status == ST_FULL);

   // Entry count follows inserts and reclaims; full and empty match the count.
   `LBCD_ASSERT_NEXT(a_insert_grows, clock, reset, do_ins, dir_count == $past(dir_count) + 1'b1)
   `LBCD_ASSERT_NEXT(a_reclaim_shrinks, clock, reset, do_rcl, dir_count == $past(dir_count) - 1'b1)
   `LBCD_ASSERT_SAME(a_empty_at_zero, clock, reset, do_emp, dir_count == '0)
   `LBCD_ASSERT_SAME(a_full_at_capacity, clock, reset, do_full, dir_count == CNT_W'(ENTRIES))

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// LRU block cache directory testbench
// Drives access and reclaim words into the directory and checks every result
// word against a local model of the slot, tag and recency-rank state. A short
// table covers the empty, full and extreme-value cases. Random traffic
// follows, drawn mostly from a small pool of block numbers so that hits,
// inserts, full misses and reclaims all occur. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import lbcd_pkg::*;

   localparam int DIR_SLOTS    = DEFAULT_ENTRIES;
   localparam int TAG_W        = DEFAULT_BLOCK_BITS;
   localparam int POOL_SIZE    = 24;
   localparam int TABLE_ROWS   = 25;
   localparam int RANDOM_WORDS = 1125;
   localparam int PHASE_WORDS  = 100;
   localparam int STALL_PCT    = 12;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [VICTIM_W-1:0] victim;
   } dir_result_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [BLOCK_NUMBER_W-1:0] blk;
      logic                      typed;
      dir_result_type            res;
   } stim_row_type;

   logic clock;
   logic reset;

   lbcd_req_if req_chan ();
   lbcd_rsp_if rsp_chan ();

   lru_block_cache_directory DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Local copy of the directory state.
   logic [TAG_W-1:0]  dir_tag   [DIR_SLOTS];
   logic              dir_live  [DIR_SLOTS];
   logic [SLOT_W-1:0] dir_rank  [DIR_SLOTS];
   logic [SLOT_W:0]   dir_count;

   dir_result_type            pending_results [$];
   logic [BLOCK_NUMBER_W-1:0] block_pool [POOL_SIZE];
   bit                        quiet_stretch;
   int                        fail_count;
   int                        idle_cycles;

   // Directed words: empty reclaim, both extremes, hit reorder, fill to full.
   stim_row_type directed_rows [TABLE_ROWS] = '{
      '{CMD_RECLAIM, 32'h0000_0000, 1'b1, '{ST_EMPTY,     4'd0,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0000_0000, 1'b1, '{ST_INSERTED,  4'd0,  32'h0000_0000}},
      '{CMD_ACCESS,  32'hFFFF_FFFF, 1'b1, '{ST_INSERTED,  4'd1,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0000_0000, 1'b1, '{ST_HIT,       4'd0,  32'h0000_0000}},
      '{CMD_RECLAIM, 32'hFFFF_FFFF, 1'b1, '{ST_RECLAIMED, 4'd1,  32'hFFFF_FFFF}},
      '{CMD_RECLAIM, 32'h0000_0000, 1'b1, '{ST_RECLAIMED, 4'd0,  32'h0000_0000}},
      '{CMD_RECLAIM, 32'h0000_0000, 1'b1, '{ST_EMPTY,     4'd0,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0000_0001, 1'b1, '{ST_INSERTED,  4'd0,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h8000_0000, 1'b1, '{ST_INSERTED,  4'd1,  32'h0000_0000}},
      '{CMD_ACCESS,  32'hAAAA_AAAA, 1'b1, '{ST_INSERTED,  4'd2,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h5555_5555, 1'b1, '{ST_INSERTED,  4'd3,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h7FFF_FFFF, 1'b1, '{ST_INSERTED,  4'd4,  32'h0000_0000}},
      '{CMD_ACCESS,  32'hFFFF_FFFE, 1'b1, '{ST_INSERTED,  4'd5,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0000_0100, 1'b1, '{ST_INSERTED,  4'd6,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0001_0000, 1'b1, '{ST_INSERTED,  4'd7,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h0100_0000, 1'b1, '{ST_INSERTED,  4'd8,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h1234_5678, 1'b1, '{ST_INSERTED,  4'd9,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h8765_4321, 1'b1, '{ST_INSERTED,  4'd10, 32'h0000_0000}},
      '{CMD_ACCESS,  32'hDEAD_BEEF, 1'b1, '{ST_INSERTED,  4'd11, 32'h0000_0000}},
      '{CMD_ACCESS,  32'h0F0F_0F0F, 1'b1, '{ST_INSERTED,  4'd12, 32'h0000_0000}},
      '{CMD_ACCESS,  32'hF0F0_F0F0, 1'b1, '{ST_INSERTED,  4'd13, 32'h0000_0000}},
      '{CMD_ACCESS,  32'h00FF_00FF, 1'b1, '{ST_INSERTED,  4'd14, 32'h0000_0000}},
      '{CMD_ACCESS,  32'hFF00_FF00, 1'b1, '{ST_INSERTED,  4'd15, 32'h0000_0000}},
      '{CMD_ACCESS,  32'h0000_0000, 1'b1, '{ST_FULL,      4'd0,  32'h0000_0000}},
      '{CMD_ACCESS,  32'h5555_5555, 1'b0, '{ST_HIT,       4'd0,  32'h0000_0000}}
   };

   // Every live entry ranked above the given one moves one step toward least recent.
   function automatic void demote_above(input logic [SLOT_W-1:0] rank);
      int i;
      for (i = 0; i < DIR_SLOTS; i++) begin
         if (dir_live[i] && dir_rank[i] > rank) begin
            dir_rank[i] = dir_rank[i] - 1'b1;
         end
      end
   endfunction

   // Apply one word to the local directory and return the result it should give.
   function automatic dir_result_type lookup_directory(input cmd_type cmd,
                                                       input logic [BLOCK_NUMBER_W-1:0] blk);
      dir_result_type   res;
      logic [TAG_W-1:0] key;
      int               i;
      res = '{ST_FULL, '0, '0};
      key = blk[TAG_W-1:0];
      if (cmd == CMD_ACCESS) begin
         // A hit makes the entry most recent.
         for (i = 0; i < DIR_SLOTS; i++) begin
            if (dir_live[i] && dir_tag[i] == key) begin
               demote_above(dir_rank[i]);
               dir_rank[i] = SLOT_W'(dir_count - 1'b1);
               res = '{ST_HIT, SLOT_W'(i), '0};
               return res;
            end
         end
         // A miss takes the lowest free slot, or reports full.
         for (i = 0; i < DIR_SLOTS; i++) begin
            if (!dir_live[i]) begin
               dir_live[i] = 1'b1;
               dir_tag[i]  = key;
               dir_rank[i] = SLOT_W'(dir_count);
               dir_count   = dir_count + 1'b1;
               res = '{ST_INSERTED, SLOT_W'(i), '0};
               return res;
            end
         end
         return res;
      end
      // A reclaim frees the least recent entry, or reports empty.
      for (i = 0; i < DIR_SLOTS; i++) begin
         if (dir_live[i] && dir_rank[i] == '0) begin
            res = '{ST_RECLAIMED, SLOT_W'(i), VICTIM_W'(dir_tag[i])};
            dir_live[i] = 1'b0;
            dir_rank[i] = '0;
            demote_above('0);
            if (dir_count != '0) begin
               dir_count = dir_count - 1'b1;
            end
            return res;
         end
      end
      res = '{ST_EMPTY, '0, '0};
      return res;
   endfunction

   // Offer one word after a random gap and queue its expected result on acceptance.
   task automatic send_word(input cmd_type cmd, input logic [BLOCK_NUMBER_W-1:0] blk,
                            input logic typed, input dir_result_type typed_res);
      dir_result_type res;
      while (!quiet_stretch && $urandom_range(99) < STALL_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.block_number <= blk;
      do @(posedge clock); while (!req_chan.ready);
      res = lookup_directory(cmd, blk);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   // Clock with a period of 4.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Consumer side stalls at random except during the quiet stretch.
   always @(posedge clock) begin
      rsp_chan.ready <= quiet_stretch || ($urandom_range(99) >= STALL_PCT);
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      dir_result_type want;
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d slot %0d victim_block %h",
                   rsp_chan.status, rsp_chan.slot, rsp_chan.victim_block);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               fail_count++;
            end
            if (rsp_chan.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_chan.slot);
               fail_count++;
            end
            if (rsp_chan.victim_block !== want.victim) begin
               $error("victim_block: expected %h, got %h", want.victim,
                      rsp_chan.victim_block);
               fail_count++;
            end
         end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: directed table, then random phases of varying reclaim weight.
   initial begin
      int                        i;
      int                        reclaim_pct;
      logic [BLOCK_NUMBER_W-1:0] blk;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_ACCESS;
      req_chan.block_number <= '0;
      quiet_stretch = 1'b0;
      fail_count    = 0;
      idle_cycles   = 0;
      reclaim_pct   = 0;
      dir_count     = '0;
      for (i = 0; i < DIR_SLOTS; i++) begin
         dir_tag[i]  = '0;
         dir_live[i] = 1'b0;
         dir_rank[i] = '0;
      end
      // A small pool keeps hits frequent; the extremes are always in it.
      for (i = 0; i < POOL_SIZE; i++) begin
         block_pool[i] = $urandom();
      end
      block_pool[0] = '0;
      block_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < TABLE_ROWS; i++) begin
         send_word(directed_rows[i].cmd, directed_rows[i].blk, directed_rows[i].typed,
                   directed_rows[i].res);
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i % PHASE_WORDS == 0) begin
            case ($urandom_range(3))
               0: begin
                  reclaim_pct = 3;
               end
               1: begin
                  reclaim_pct = 15;
               end
               2: begin
                  reclaim_pct = 35;
               end
               default: begin
                  reclaim_pct = 70;
               end
            endcase
         end
         quiet_stretch = (i >= 400 && i < 600);
         // Hold off until the directory has answered every word so far.
         if (i == 250 || i == 800) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end
         if ($urandom_range(99) < reclaim_pct) begin
            send_word(CMD_RECLAIM, $urandom(), 1'b0, '0);
         end else begin
            if ($urandom_range(9) == 0) begin
               blk = $urandom();
            end else begin
               blk = block_pool[$urandom_range(POOL_SIZE - 1)];
            end
            send_word(CMD_ACCESS, blk, 1'b0, '0);
         end
      end
      req_chan.valid <= 1'b0;
      quiet_stretch = 1'b0;

      // Drain the outstanding results, then allow for any stray word.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
